// ===== hdl/mcpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// mcpwm_pkg
// Shared widths, codes and reset values for the four-channel PWM unit.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

  localparam int CHANNELS   = 4;
  localparam int DUTY_W     = 16;
  localparam int CH_W       = 2;
  localparam int LEVELS_W   = 4;
  localparam int ACT_W      = 3;
  localparam int CFG_IDX_W  = 1;

  localparam logic [DUTY_W-1:0] PERIOD_RESET   = 16'd255;
  localparam logic [DUTY_W-1:0] PRESCALE_RESET = 16'd1;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_PERIOD   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESCALE = 1'd1;

endpackage

// ===== hdl/mcpwm_ifs.sv =====
// ----------------------------------------------------------------------------
// mcpwm channel interfaces
// Valid/ready channels for commands, results and register writes.
// ----------------------------------------------------------------------------
interface mcpwm_in_if import mcpwm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [CH_W-1:0]   channel;
  logic [DUTY_W-1:0] duty_value;

  modport source (output valid, command, channel, duty_value, input ready);
  modport sink   (input valid, command, channel, duty_value, output ready);
endinterface

interface mcpwm_out_if import mcpwm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [LEVELS_W-1:0] pwm_levels;
  logic [ACT_W-1:0]    active_channels;
  logic                counter_running;

  modport source (output valid, pwm_levels, active_channels, counter_running,
                  input ready);
  modport sink   (input valid, pwm_levels, active_channels, counter_running,
                  output ready);
endinterface

interface mcpwm_cfg_if import mcpwm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DUTY_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/multi_channel_pwm_with_auto_run_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pwm_with_auto_run_unit
// Four-channel edge-aligned PWM with shared prescaler and auto start/stop.
// ----------------------------------------------------------------------------
// One command transaction is accepted per clock while the input is ready.
// The duty store, channel count, prescaler, counter and output register
// all update at the accepting edge. The input is ready whenever the output
// register is empty or being drained, so a stalled consumer holds off new
// commands only while its result is still waiting. Register writes are
// always accepted and take effect at the next edge.
module multi_channel_pwm_with_auto_run_unit
  import mcpwm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  mcpwm_in_if.sink    in_ch,
  mcpwm_out_if.source out_ch,
  mcpwm_cfg_if.sink   cfg
);

  logic [DUTY_W-1:0]   period;
  logic [DUTY_W-1:0]   prescale_divide;
  logic [DUTY_W-1:0]   duty_store [CHANNELS];
  logic [ACT_W-1:0]    active_count;
  logic [DUTY_W-1:0]   prescale_count;
  logic [DUTY_W-1:0]   cycle_count;

  logic [DUTY_W-1:0]   duty_next [CHANNELS];
  logic [ACT_W-1:0]    active_next;
  logic [DUTY_W-1:0]   prescale_next;
  logic [DUTY_W-1:0]   cycle_next;
  logic [LEVELS_W-1:0] levels_next;

  logic                out_valid;
  logic [LEVELS_W-1:0] pwm_levels;
  logic [ACT_W-1:0]    active_channels;
  logic                counter_running;

  logic                in_acc;
  logic [DUTY_W-1:0]   duty_clamped;
  logic [DUTY_W-1:0]   divide_eff;
  logic [DUTY_W:0]     prescale_inc;
  logic [DUTY_W:0]     cycle_inc;
  logic [ACT_W-1:0]    active_dec;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign cfg.ready   = 1'b1;

  assign out_ch.valid           = out_valid;
  assign out_ch.pwm_levels      = pwm_levels;
  assign out_ch.active_channels = active_channels;
  assign out_ch.counter_running = counter_running;

  assign duty_clamped = (in_ch.duty_value > period) ? period : in_ch.duty_value;
  assign divide_eff   = (prescale_divide == '0) ? DUTY_W'(1) : prescale_divide;
  assign prescale_inc = {1'b0, prescale_count} + (DUTY_W+1)'(1);
  assign cycle_inc    = {1'b0, cycle_count} + (DUTY_W+1)'(1);
  assign active_dec   = active_count - ACT_W'(1);

  always_comb begin
    duty_next     = duty_store;
    active_next   = active_count;
    prescale_next = prescale_count;
    cycle_next    = cycle_count;
    if (in_acc) begin
      if (in_ch.command == CMD_SET) begin
        for (int i = 0; i < CHANNELS; i++) begin
          if (in_ch.channel == CH_W'(i)) begin
            duty_next[i] = duty_clamped;
            if (duty_clamped != '0 && duty_store[i] == '0) begin
              active_next = active_count + ACT_W'(1);
              if (active_count == '0) begin
                prescale_next = '0;
                cycle_next    = '0;
              end
            end else if (duty_clamped == '0 && duty_store[i] != '0) begin
              active_next = active_dec;
              if (active_dec == '0) begin
                prescale_next = '0;
                cycle_next    = '0;
              end
            end
          end
        end
      end else if (active_count != '0) begin
        if (prescale_inc < {1'b0, divide_eff}) begin
          prescale_next = prescale_inc[DUTY_W-1:0];
        end else begin
          prescale_next = '0;
          if (period <= DUTY_W'(1) || cycle_inc >= {1'b0, period}) begin
            cycle_next = '0;
          end else begin
            cycle_next = cycle_inc[DUTY_W-1:0];
          end
        end
      end
    end
  end

  always_comb begin
    levels_next = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      levels_next[i] = (active_next != '0) && (cycle_next < duty_next[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period          <= PERIOD_RESET;
      prescale_divide <= PRESCALE_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_PERIOD:   period          <= cfg.data;
        REG_PRESCALE: prescale_divide <= cfg.data;
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        duty_store[i] <= '0;
      end
      active_count   <= '0;
      prescale_count <= '0;
      cycle_count    <= '0;
    end else begin
      duty_store     <= duty_next;
      active_count   <= active_next;
      prescale_count <= prescale_next;
      cycle_count    <= cycle_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pwm_levels      <= levels_next;
      active_channels <= active_next;
      counter_running <= (active_next != '0);
    end
  end

  // stopped counter is parked at zero
  assert property (@(posedge clk) disable iff (rst)
    (active_count == '0) |-> (prescale_count == '0 && cycle_count == '0))
    else $error("counter not held at zero while stopped");

  assert property (@(posedge clk) disable iff (rst)
    active_count <= ACT_W'(CHANNELS))
    else $error("active channel count out of range");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (counter_running == (active_channels != '0)))
    else $error("running flag disagrees with channel count");

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ch.ready) |-> !in_ch.ready)
    else $error("command taken while result stalled");

  assert property (@(posedge clk) disable iff (rst)
    in_acc |=> out_valid)
    else $error("accepted command produced no result");

endmodule

// ===== bench/multi_channel_pwm_with_auto_run_unit_test.sv =====
// ----------------------------------------------------------------------------
// multi_channel_pwm_with_auto_run_unit_test
// Drives set and tick commands into the PWM unit over valid/ready channels,
// with random gaps and stalls on both sides. A behavioral model of duty
// clamping, auto start/stop, prescaler and counter predicts every result
// transaction, and each one is checked field by field. Directed cases cover
// the start and stop edges and odd register values; random phases run
// under several period and prescale settings.
// ----------------------------------------------------------------------------
module multi_channel_pwm_with_auto_run_unit_test;
  import mcpwm_pkg::*;

  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 75;

  typedef struct packed {
    logic [LEVELS_W-1:0] levels;
    logic [ACT_W-1:0]    active;
    logic                running;
  } pwm_status_t;

  logic clk;
  logic rst;

  mcpwm_in_if  in_ch();
  mcpwm_out_if out_ch();
  mcpwm_cfg_if cfg_ch();

  multi_channel_pwm_with_auto_run_unit u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg_ch)
  );

  // model state
  logic [DUTY_W-1:0] period_cfg   = PERIOD_RESET;
  logic [DUTY_W-1:0] prescale_cfg = PRESCALE_RESET;
  logic [DUTY_W-1:0] duty_mem [CHANNELS] = '{default: '0};
  logic [ACT_W-1:0]  active_cnt   = '0;
  logic [DUTY_W-1:0] prescale_cnt = '0;
  logic [DUTY_W-1:0] cycle_cnt    = '0;

  pwm_status_t pending_status_q [$];
  int          mismatch_count = 0;
  bit          no_idle        = 1'b0;
  bit          hold_output    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("multi_channel_pwm_with_auto_run_unit_test: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (no_idle || roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic pwm_status_t advance_pwm(logic cmd, logic [CH_W-1:0] ch,
                                              logic [DUTY_W-1:0] req);
    logic [DUTY_W-1:0] clamped;
    logic [DUTY_W:0]   div;
    logic [DUTY_W:0]   nxt;
    pwm_status_t       st;
    if (cmd == CMD_SET) begin
      if (int'(ch) < CHANNELS) begin
        clamped = (req > period_cfg) ? period_cfg : req;
        if (clamped != 0 && duty_mem[ch] == 0) begin
          if (active_cnt == 0) begin
            prescale_cnt = '0;
            cycle_cnt    = '0;
          end
          active_cnt = active_cnt + ACT_W'(1);
        end else if (clamped == 0 && duty_mem[ch] != 0) begin
          active_cnt = active_cnt - ACT_W'(1);
          if (active_cnt == 0) begin
            prescale_cnt = '0;
            cycle_cnt    = '0;
          end
        end
        duty_mem[ch] = clamped;
      end
    end else if (active_cnt != 0) begin
      div = (prescale_cfg == 0) ? 17'd1 : {1'b0, prescale_cfg};
      nxt = {1'b0, prescale_cnt} + 17'd1;
      if (nxt < div) begin
        prescale_cnt = nxt[DUTY_W-1:0];
      end else begin
        prescale_cnt = '0;
        nxt = {1'b0, cycle_cnt} + 17'd1;
        if (period_cfg <= 1 || nxt >= {1'b0, period_cfg}) cycle_cnt = '0;
        else cycle_cnt = nxt[DUTY_W-1:0];
      end
    end
    st.levels = '0;
    if (active_cnt != 0) begin
      for (int i = 0; i < CHANNELS; i++) st.levels[i] = cycle_cnt < duty_mem[i];
    end
    st.active  = active_cnt;
    st.running = active_cnt != 0;
    return st;
  endfunction

  // result checker
  initial begin
    pwm_status_t exp_st;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        if (pending_status_q.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected transaction levels %h active %0d running %b",
                   $time, out_ch.pwm_levels, out_ch.active_channels,
                   out_ch.counter_running);
        end else begin
          exp_st = pending_status_q.pop_front();
          if (out_ch.pwm_levels !== exp_st.levels) begin
            mismatch_count++;
            $display("%0t: pwm_levels expected %h actual %h",
                     $time, exp_st.levels, out_ch.pwm_levels);
          end
          if (out_ch.active_channels !== exp_st.active) begin
            mismatch_count++;
            $display("%0t: active_channels expected %0d actual %0d",
                     $time, exp_st.active, out_ch.active_channels);
          end
          if (out_ch.counter_running !== exp_st.running) begin
            mismatch_count++;
            $display("%0t: counter_running expected %b actual %b",
                     $time, exp_st.running, out_ch.counter_running);
          end
        end
      end
    end
  end

  // result consumer: random stalls, plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
      end else if (stall_left != 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = pick_gap();
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // valid is left high on return so back-to-back transactions keep it up
  task automatic send_cmd(logic cmd, logic [CH_W-1:0] ch, logic [DUTY_W-1:0] req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.command    <= cmd;
    in_ch.channel    <= ch;
    in_ch.duty_value <= req;
    do @(posedge clk); while (!in_ch.ready);
    pending_status_q.push_back(advance_pwm(cmd, ch, req));
  endtask

  task automatic set_duty(logic [CH_W-1:0] ch, logic [DUTY_W-1:0] req);
    send_cmd(CMD_SET, ch, req);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_cmd(CMD_TICK, '0, '0);
  endtask

  task automatic drain_pending();
    in_ch.valid <= 1'b0;
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_timing(logic [DUTY_W-1:0] per, logic [DUTY_W-1:0] pre);
    drain_pending();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_PERIOD;
    cfg_ch.data  <= per;
    do @(posedge clk); while (!cfg_ch.ready);
    period_cfg = per;
    cfg_ch.index <= REG_PRESCALE;
    cfg_ch.data  <= pre;
    do @(posedge clk); while (!cfg_ch.ready);
    prescale_cfg = pre;
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_start_stop();
    send_ticks(1);
    set_duty(0, 16'h0000);
    set_duty(0, 16'hFFFF);
    send_ticks(1);
    set_duty(1, 16'h0001);
    send_ticks(1);
    set_duty(0, 16'h8000);
    set_duty(0, 16'h0000);
    set_duty(1, 16'h0000);
    send_ticks(1);
    drain_pending();
  endtask

  task automatic test_odd_registers();
    set_timing(16'd0, 16'd0);
    set_duty(3, 16'd5);
    send_ticks(1);
    set_timing(16'd1, 16'd0);
    set_duty(3, 16'd5);
    send_ticks(2);
    set_duty(2, 16'hFFFF);
    set_timing(16'd6, 16'd1);
    set_duty(3, 16'd0);
    set_duty(2, 16'd0);
    set_duty(0, 16'd4);
    send_ticks(4);
    // lowered period: counter above it and duty above it
    set_timing(16'd3, 16'd1);
    send_ticks(3);
    set_timing(16'hFFFF, 16'hFFFF);
    set_duty(1, 16'hFFFF);
    send_ticks(2);
    set_duty(0, 16'd0);
    set_duty(1, 16'd0);
    drain_pending();
  endtask

  task automatic test_random_traffic();
    logic [DUTY_W-1:0] per;
    logic [DUTY_W-1:0] pre;
    int                roll;
    int                top;
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin per = 16'd2; pre = 16'd1; end
        1: begin per = 16'hFFFF; pre = 16'd1; end
        2: begin per = 16'd20; pre = 16'hFFFF; end
        default: begin
          roll = $urandom_range(0, 9);
          per  = (roll == 0) ? 16'($urandom_range(0, 1)) : 16'($urandom_range(2, 24));
          roll = $urandom_range(0, 9);
          if (roll < 7) pre = 16'($urandom_range(1, 4));
          else if (roll < 9) pre = 16'd0;
          else pre = 16'($urandom_range(5, 30));
        end
      endcase
      set_timing(per, pre);
      no_idle = (phase == 4);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == 10) hold_output = 1'b1;
        if ($urandom_range(0, 9) < 3) begin
          roll = $urandom_range(0, 9);
          top  = int'(period_cfg) + 2;
          if (top > 65535) top = 65535;
          if (roll < 3) set_duty(CH_W'($urandom_range(0, 3)), 16'd0);
          else if (roll < 7) set_duty(CH_W'($urandom_range(0, 3)),
                                      16'($urandom_range(0, top)));
          else set_duty(CH_W'($urandom_range(0, 3)), 16'($urandom));
        end else begin
          send_ticks(1);
        end
      end
      no_idle = 1'b0;
    end
    drain_pending();
  endtask

  initial begin
    rst              <= 1'b1;
    in_ch.valid      <= 1'b0;
    in_ch.command    <= CMD_SET;
    in_ch.channel    <= '0;
    in_ch.duty_value <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= REG_PERIOD;
    cfg_ch.data      <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_start_stop();
    test_odd_registers();
    test_random_traffic();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && pending_status_q.size() == 0) begin
      $display("multi_channel_pwm_with_auto_run_unit_test: done, clean");
    end else begin
      $display("multi_channel_pwm_with_auto_run_unit_test: done, errors");
    end
    $finish;
  end

endmodule
